[hdl/slt_pkg.sv]
// ----------------------------------------------------------------------------
// slt_pkg
// shared codes, cell control types and widths for the sorted list table
// ----------------------------------------------------------------------------
package slt_pkg;

	localparam int DATA_W  = 32;
	localparam int CMD_W   = 3;
	localparam int STAT_W  = 2;
	localparam int COUNT_W = 6;

	// request operation codes
	localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_DELETE  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_SEARCH  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_POP_MIN = 3'd3;
	localparam logic [CMD_W-1:0] CMD_POP_MAX = 3'd4;

	// result status codes
	localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd2;
	localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

	// what every cell does on the update cycle
	typedef enum logic [1:0] {
		MODE_HOLD,
		MODE_INSERT,
		MODE_DELETE,
		MODE_SHIFT
	} cell_mode_t;

	typedef struct packed {
		cell_mode_t               mode;
		logic signed [DATA_W-1:0] value;
	} cell_ctl_t;

	// per-cell compare flags, each qualified by the cell's valid bit
	typedef struct packed {
		logic le;
		logic lt;
		logic eq;
	} cell_flags_t;

endpackage

[hdl/sorted_list_table_unit.sv]
// ----------------------------------------------------------------------------
// sorted_list_table_unit
// ascending table of signed 32-bit values held in a chain of compare cells
// ----------------------------------------------------------------------------
// result: the request is captured, then the cell chain updates and the output
//   register loads the result; one request in flight, the next is captured only
//   after the update retires (one parallel compare-and-shift across the whole cell chain)
// a waiting result does not block the next capture; the update only waits
//   when the output register is still full and stalled
// reset: clears the entry count and valid flags; cell contents are not reset
module sorted_list_table_unit
	import slt_pkg::*;
#(
	parameter int CAPACITY = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [CMD_W-1:0]         cmd,
	input  logic signed [DATA_W-1:0] value,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [STAT_W-1:0]        status,
	output logic signed [DATA_W-1:0] result_value,
	output logic [COUNT_W-1:0]       entry_count
);

	localparam int CW = $clog2(CAPACITY + 1);

	// captured request
	logic                     valid_s1;
	logic [CMD_W-1:0]         cmd_s1;
	logic signed [DATA_W-1:0] value_s1;

	// table occupancy
	logic [CW-1:0]            count_q;
	logic [CW-1:0]            count_next;

	// output register
	logic                     out_valid_q;
	logic [STAT_W-1:0]        status_q;
	logic signed [DATA_W-1:0] result_q;

	// cell chain
	cell_ctl_t                ctl;
	logic signed [DATA_W-1:0] cell_data  [CAPACITY];
	cell_flags_t              cell_flags [CAPACITY];
	logic [CAPACITY-1:0]      cell_valid;
	logic [CAPACITY-1:0]      cell_eq;

	logic                     in_take;
	logic                     done;
	logic                     full;
	logic                     empty;
	logic                     found;
	logic signed [DATA_W-1:0] last_data;
	logic [STAT_W-1:0]        status_next;
	logic signed [DATA_W-1:0] result_next;
	logic [CW+COUNT_W-1:0]    count_ext;

	// one request in flight; the next is captured once the update retires
	assign in_stall = valid_s1;
	assign in_take  = in_valid && !in_stall;
	// the update retires only when the output register can take its result
	assign done     = valid_s1 && (!out_valid_q || !out_stall);

	assign full  = (count_q == CW'(CAPACITY));
	assign empty = (count_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (done) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			cmd_s1   <= cmd;
			value_s1 <= value;
		end
	end

	// cell i holds a live entry when it sits below the count
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			cell_valid[i] = (count_q > CW'(i));
			cell_eq[i]    = cell_flags[i].eq;
		end
	end

	// entries are equal-contiguous, so any match means the first match exists
	assign found = |cell_eq;

	// largest entry: the live cell whose upper neighbor is not live
	always_comb begin
		last_data = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (cell_valid[i] && (i == CAPACITY - 1 || !cell_valid[(i + 1) % CAPACITY])) begin
				last_data = last_data | cell_data[i];
			end
		end
	end

	// request decode: cell mode, status, result and new count
	always_comb begin
		ctl.mode    = MODE_HOLD;
		ctl.value   = value_s1;
		status_next = ST_OK;
		result_next = '0;
		count_next  = count_q;
		if (done) begin
			case (cmd_s1)
				CMD_INSERT: begin
					if (full) begin
						status_next = ST_FULL;
					end else begin
						ctl.mode   = MODE_INSERT;
						count_next = count_q + CW'(1);
					end
				end
				CMD_DELETE: begin
					if (found) begin
						ctl.mode    = MODE_DELETE;
						result_next = value_s1;
						count_next  = count_q - CW'(1);
					end else begin
						status_next = ST_NOTFOUND;
					end
				end
				CMD_SEARCH: begin
					if (found) begin
						result_next = value_s1;
					end else begin
						status_next = ST_NOTFOUND;
					end
				end
				CMD_POP_MIN: begin
					if (empty) begin
						status_next = ST_EMPTY;
					end else begin
						ctl.mode    = MODE_SHIFT;
						result_next = cell_data[0];
						count_next  = count_q - CW'(1);
					end
				end
				CMD_POP_MAX: begin
					// dropping the top entry only needs the count to fall
					if (empty) begin
						status_next = ST_EMPTY;
					end else begin
						result_next = last_data;
						count_next  = count_q - CW'(1);
					end
				end
				default: begin
					status_next = ST_OK;
				end
			endcase
		end
	end

	// the chain: each cell sees its lower neighbor's flag and data for
	// inserts and its upper neighbor's data for deletes and min pops
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic                     left_le;
		logic signed [DATA_W-1:0] left_data;
		logic signed [DATA_W-1:0] right_data;

		if (g == 0) begin : g_first
			assign left_le   = 1'b1;
			assign left_data = value_s1;
		end else begin : g_inner
			assign left_le   = cell_flags[g-1].le;
			assign left_data = cell_data[g-1];
		end

		if (g == CAPACITY - 1) begin : g_last
			assign right_data = cell_data[g];
		end else begin : g_upper
			assign right_data = cell_data[g+1];
		end

		slt_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.valid      (cell_valid[g]),
			.left_le    (left_le),
			.left_data  (left_data),
			.right_data (right_data),
			.data       (cell_data[g]),
			.flags      (cell_flags[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_next;
			if (done) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			status_q <= status_next;
			result_q <= result_next;
		end
	end

	// count only moves when a new result loads, so it tracks the held result
	assign count_ext    = {{COUNT_W{1'b0}}, count_q};
	assign entry_count  = count_ext[COUNT_W-1:0];
	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign result_value = result_q;

endmodule

[hdl/slt_cell.sv]
// ----------------------------------------------------------------------------
// slt_cell
// one entry of the sorted chain: compares against the request value and
// takes its next contents from itself, the request, or a neighbor
// ----------------------------------------------------------------------------
module slt_cell
	import slt_pkg::*;
(
	input  logic                     clk,
	input  cell_ctl_t                ctl,
	input  logic                     valid,
	input  logic                     left_le,
	input  logic signed [DATA_W-1:0] left_data,
	input  logic signed [DATA_W-1:0] right_data,
	output logic signed [DATA_W-1:0] data,
	output cell_flags_t              flags
);

	logic signed [DATA_W-1:0] data_q;
	logic signed [DATA_W-1:0] data_next;

	always_comb begin
		flags.le = valid && (data_q <= ctl.value);
		flags.lt = valid && (data_q <  ctl.value);
		flags.eq = valid && (data_q == ctl.value);
	end

	always_comb begin
		data_next = data_q;
		case (ctl.mode)
			MODE_INSERT: begin
				// entries above the insert point move up by one
				if (!flags.le) begin
					data_next = left_le ? ctl.value : left_data;
				end
			end
			MODE_DELETE: begin
				// entries from the first match upward move down by one
				if (!flags.lt) begin
					data_next = right_data;
				end
			end
			MODE_SHIFT: begin
				data_next = right_data;
			end
			default: begin
				data_next = data_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_next;
	end

	assign data = data_q;

endmodule

[hdl/slt_checker.sv]
// ----------------------------------------------------------------------------
// slt_checker
// port-level checks on the sorted list table, bound to the top level
// ----------------------------------------------------------------------------
module slt_checker
	import slt_pkg::*;
#(
	parameter int CAPACITY = 32
) (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_stall,
	input logic [CMD_W-1:0]         cmd,
	input logic signed [DATA_W-1:0] value,
	input logic                     out_valid,
	input logic                     out_stall,
	input logic [STAT_W-1:0]        status,
	input logic signed [DATA_W-1:0] result_value,
	input logic [COUNT_W-1:0]       entry_count
);

	localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(CAPACITY);

	// a taken transaction stalls the input in the following cycle
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken back to back");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FULL |-> entry_count == FULL_COUNT && result_value == '0)
		else $error("full status with wrong count or value");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_EMPTY |-> entry_count == '0 && result_value == '0)
		else $error("empty status with wrong count or value");

	a_notfound_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_NOTFOUND |-> result_value == '0)
		else $error("not found with nonzero value");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(result_value))
		else $error("stalled result changed");

endmodule

bind sorted_list_table_unit slt_checker #(.CAPACITY(CAPACITY)) u_slt_checker (.*);
